FILE: rtl/cwr_pkg.sv
// ----------------------------------------------------------------------------
// cwr_pkg
// shared types and constants of the core work range calculator
// ----------------------------------------------------------------------------
package cwr_pkg;

    localparam int DEF_MAX_ENTRIES  = 4;
    localparam int DEF_MAX_CLUSTERS = 8;

    localparam int PACKED_ENTRIES   = 4;
    localparam int PACKED_CLUSTERS  = 8;

    localparam int IDX_W   = 6;
    localparam int WIN_W   = 12;
    localparam int CNT_W   = 4;
    localparam int CID_W   = 3;
    localparam int SZ_W    = 6;
    localparam int BASE_W  = 14;
    localparam int POS_W   = 15;
    localparam int STEP_W  = 12;
    localparam int RANGE_W = 27;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 48;

    localparam int Q_DEPTH = 4;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_ENTRY_COUNT    = 3'd0,
        CFG_ENTRY_CLUSTERS = 3'd1,
        CFG_ENTRY_WINDOWS  = 3'd2,
        CFG_CORE_COUNTS    = 3'd3,
        CFG_STEP           = 3'd4
    } t_cfg_addr;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        t_status           status;
        logic [WIN_W-1:0]  win;
        logic [SZ_W-1:0]   sz;
        logic [IDX_W-1:0]  idx;
        logic [BASE_W-1:0] base;
    } t_job;

endpackage

FILE: rtl/core_work_range_calc.sv
// ----------------------------------------------------------------------------
// core_work_range_calc
// answers a global core index with that core's scaled work range
// ----------------------------------------------------------------------------
// One core index is taken per cycle while the queue has room; each gives one
// result in order, after the four-deep job queue, twelve stages of the window
// divider (one quotient bit per stage), one stage for offset and remainder
// share, and one for the step multipliers and the output register. The
// classifier in front of the queue resolves the entry search in the cycle of
// the transfer; the queue takes up to four items while the output side stalls.
module core_work_range_calc import cwr_pkg::*; #(
    parameter int MAX_ENTRIES  = DEF_MAX_ENTRIES,
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_A_W-1:0]        i_cfg_addr,
    input  logic [CFG_D_W-1:0]        i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [IDX_W-1:0]          i_core_index,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [RANGE_W-1:0] o_range_start,
    output logic signed [RANGE_W-1:0] o_range_end,
    output logic signed [STEP_W:0]    o_step_out,
    output logic [1:0]                o_status
);

    logic [2:0]                       r_entry_count;
    logic [PACKED_ENTRIES*CID_W-1:0]  r_entry_clusters;
    logic [PACKED_ENTRIES*WIN_W-1:0]  r_entry_windows;
    logic [PACKED_CLUSTERS*CNT_W-1:0] r_core_counts;
    logic [STEP_W-1:0]                r_step;

    t_job fr_job;
    t_job q_job;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count    <= '0;
            r_entry_clusters <= '0;
            r_entry_windows  <= '0;
            r_core_counts    <= '0;
            r_step           <= STEP_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_addr'(i_cfg_addr))
                CFG_ENTRY_COUNT:    r_entry_count    <= i_cfg_data[2:0];
                CFG_ENTRY_CLUSTERS: r_entry_clusters <= i_cfg_data[PACKED_ENTRIES*CID_W-1:0];
                CFG_ENTRY_WINDOWS:  r_entry_windows  <= i_cfg_data[PACKED_ENTRIES*WIN_W-1:0];
                CFG_CORE_COUNTS:    r_core_counts    <= i_cfg_data[PACKED_CLUSTERS*CNT_W-1:0];
                CFG_STEP:           r_step           <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = !q_full;
    assign push       = i_in_valid && !q_full;

    cwr_front #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_front (
        .i_core_index     (i_core_index),
        .i_entry_count    (r_entry_count),
        .i_entry_clusters (r_entry_clusters),
        .i_entry_windows  (r_entry_windows),
        .i_core_counts    (r_core_counts),
        .o_job            (fr_job)
    );

    cwr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (fr_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    cwr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_job         (q_job),
        .o_pop         (q_pop),
        .i_step        (r_step),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_range_start (o_range_start),
        .o_range_end   (o_range_end),
        .o_step_out    (o_step_out),
        .o_status      (o_status)
    );

endmodule

FILE: rtl/cwr_front.sv
// ----------------------------------------------------------------------------
// cwr_front
// classifies a core index: finds its entry, local index and base position
// ----------------------------------------------------------------------------
module cwr_front import cwr_pkg::*; #(
    parameter int MAX_ENTRIES  = DEF_MAX_ENTRIES,
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
) (
    input  logic [IDX_W-1:0]                i_core_index,
    input  logic [2:0]                      i_entry_count,
    input  logic [PACKED_ENTRIES*CID_W-1:0] i_entry_clusters,
    input  logic [PACKED_ENTRIES*WIN_W-1:0] i_entry_windows,
    input  logic [PACKED_CLUSTERS*CNT_W-1:0] i_core_counts,
    output t_job                            o_job
);

    localparam int NE = (MAX_ENTRIES < PACKED_ENTRIES) ? MAX_ENTRIES : PACKED_ENTRIES;

    logic [2:0]       n_eff;
    logic [CID_W-1:0] clus  [PACKED_ENTRIES];
    logic [WIN_W-1:0] win   [PACKED_ENTRIES];
    logic [CNT_W-1:0] cap   [PACKED_ENTRIES];
    logic [SZ_W-1:0]  usab  [PACKED_ENTRIES];
    logic             act   [PACKED_ENTRIES];

    assign n_eff = (i_entry_count > 3'(NE)) ? 3'(NE) : i_entry_count;

    always_comb begin
        logic [CNT_W-1:0] cnt;
        for (int i = 0; i < PACKED_ENTRIES; i++) begin
            clus[i] = i_entry_clusters[i*CID_W +: CID_W];
            win[i]  = i_entry_windows[i*WIN_W +: WIN_W];
            act[i]  = (3'(i) < n_eff);
            cnt     = '0;
            if (int'(clus[i]) < MAX_CLUSTERS) begin
                cnt = i_core_counts[{clus[i], 2'b00} +: CNT_W];
            end
            cap[i] = (win[i] < WIN_W'(cnt)) ? win[i][CNT_W-1:0] : cnt;
        end
    end

    always_comb begin
        for (int i = 0; i < PACKED_ENTRIES; i++) begin
            usab[i] = '0;
            for (int j = 0; j < PACKED_ENTRIES; j++) begin
                if (act[j] && clus[j] == clus[i]) begin
                    usab[i] = usab[i] + SZ_W'(cap[j]);
                end
            end
        end
    end

    // walk the entries in order
    always_comb begin
        logic [IDX_W-1:0]  idx;
        logic [BASE_W-1:0] base;
        logic              found;
        idx   = i_core_index;
        base  = '0;
        found = 1'b0;
        o_job.win  = '0;
        o_job.sz   = '0;
        o_job.idx  = '0;
        o_job.base = '0;
        for (int i = 0; i < PACKED_ENTRIES; i++) begin
            if (act[i] && !found) begin
                if (idx < usab[i]) begin
                    found      = 1'b1;
                    o_job.win  = win[i];
                    o_job.sz   = usab[i];
                    o_job.idx  = idx;
                    o_job.base = base;
                end else begin
                    idx  = idx - usab[i];
                    base = base + BASE_W'(win[i]);
                end
            end
        end
        if (n_eff == 3'd0) begin
            o_job.status = ST_EMPTY;
        end else if (found) begin
            o_job.status = ST_OK;
        end else begin
            o_job.status = ST_RANGE;
        end
    end

endmodule

FILE: rtl/cwr_queue.sv
// ----------------------------------------------------------------------------
// cwr_queue
// short job queue between the classifier and the range pipeline
// ----------------------------------------------------------------------------
module cwr_queue import cwr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    localparam int PTR_W = $clog2(Q_DEPTH);

    t_job               r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [PTR_W:0]     r_cnt;
    logic               do_pop;

    assign o_full  = (r_cnt == (PTR_W+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/cwr_back.sv
// ----------------------------------------------------------------------------
// cwr_back
// pipelined window split: one divider bit per stage, then offset and scale
// ----------------------------------------------------------------------------
module cwr_back import cwr_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  t_job                      i_job,
    output logic                      o_pop,
    input  logic [STEP_W-1:0]         i_step,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [RANGE_W-1:0] o_range_start,
    output logic signed [RANGE_W-1:0] o_range_end,
    output logic signed [STEP_W:0]    o_step_out,
    output logic [1:0]                o_status
);

    localparam int DIV_STAGES = WIN_W;

    typedef struct packed {
        t_job             job;
        logic [SZ_W-1:0]  rem;
        logic [WIN_W-1:0] quo;
    } t_div;

    t_div               r_dv  [DIV_STAGES+1];
    logic               r_dvv [DIV_STAGES+1];
    t_div               n_dv  [DIV_STAGES];
    t_status            r_cs_status;
    logic [POS_W-1:0]   r_cs_start;
    logic [POS_W-1:0]   r_cs_end;
    logic               r_cs_v;
    logic               r_out_v;
    logic signed [RANGE_W-1:0] r_start;
    logic signed [RANGE_W-1:0] r_end;
    logic signed [STEP_W:0]    r_stepo;
    logic [1:0]                r_status;
    logic               adv;
    logic [POS_W-1:0]   n_start;
    logic [POS_W-1:0]   n_end;

    assign adv   = !r_out_v || i_out_ready;
    assign o_pop = adv;

    // restoring division, msb first
    always_comb begin
        logic [SZ_W:0] part;
        for (int k = 0; k < DIV_STAGES; k++) begin
            n_dv[k] = r_dv[k];
            part    = {r_dv[k].rem, r_dv[k].job.win[WIN_W-1-k]};
            if (part >= {1'b0, r_dv[k].job.sz}) begin
                part                       = part - {1'b0, r_dv[k].job.sz};
                n_dv[k].quo[WIN_W-1-k]     = 1'b1;
            end
            n_dv[k].rem = part[SZ_W-1:0];
        end
    end

    always_comb begin
        logic [WIN_W+IDX_W-1:0] prod;
        logic [IDX_W-1:0]       low;
        t_div                   d;
        d       = r_dv[DIV_STAGES];
        prod    = (WIN_W+IDX_W)'(d.quo) * (WIN_W+IDX_W)'(d.job.idx);
        low     = (d.rem < d.job.idx) ? d.rem : d.job.idx;
        n_start = POS_W'(d.job.base) + POS_W'(prod) + POS_W'(low);
        n_end   = n_start + POS_W'(d.quo) + POS_W'(d.job.idx < d.rem);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv[0].job <= i_job;
            r_dv[0].rem <= '0;
            r_dv[0].quo <= '0;
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dv[k+1] <= n_dv[k];
            end
            r_cs_status <= r_dv[DIV_STAGES].job.status;
            r_cs_start  <= n_start;
            r_cs_end    <= n_end;
            case (r_cs_status)
                ST_OK: begin
                    r_start <= RANGE_W'(r_cs_start) * RANGE_W'(i_step);
                    r_end   <= RANGE_W'(r_cs_end) * RANGE_W'(i_step);
                    r_stepo <= {1'b0, i_step};
                end
                ST_EMPTY: begin
                    r_start <= '1;
                    r_end   <= '1;
                    r_stepo <= '1;
                end
                default: begin
                    r_start <= '0;
                    r_end   <= '0;
                    r_stepo <= '0;
                end
            endcase
            r_status <= r_cs_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_dvv[k] <= 1'b0;
            end
            r_cs_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_dvv[0] <= i_valid;
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dvv[k+1] <= r_dvv[k];
            end
            r_cs_v  <= r_dvv[DIV_STAGES];
            r_out_v <= r_cs_v;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_range_start = r_start;
    assign o_range_end   = r_end;
    assign o_step_out    = r_stepo;
    assign o_status      = r_status;

endmodule

FILE: test/tb_core_work_range_calc.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_core_work_range_calc
// self-checking bench for the core work range calculator
// ----------------------------------------------------------------------------
// A directed pass covers the empty configuration, an index past the last core,
// an entry count above the entry limit, clusters with no cores and entries
// with no usable cores, and extreme windows and steps. Register settings then
// follow, two fixed, the rest random, each run under four pacing modes on both
// handshakes. A scoreboard predicts every work range from its own copy of the
// registers and checks the results in order, field by field.
// ----------------------------------------------------------------------------
module tb_core_work_range_calc import cwr_pkg::*; ();

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 7;
    localparam int SETTLE_CYCLES   = 24;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_SETTINGS = 9;
    localparam int ITEMS_PER_MODE  = 25;
    localparam int MAX_PRINTED     = 30;

    typedef struct packed {
        logic signed [RANGE_W-1:0] range_start;
        logic signed [RANGE_W-1:0] range_end;
        logic signed [STEP_W:0]    step_out;
        t_status                   status;
    } t_work_range;

    class range_scoreboard;
        logic [2:0]                          entry_count;
        logic [PACKED_ENTRIES*CID_W-1:0]     entry_clusters;
        logic [PACKED_ENTRIES*WIN_W-1:0]     entry_windows;
        logic [PACKED_CLUSTERS*CNT_W-1:0]    core_counts;
        logic [STEP_W-1:0]                   step;
        t_work_range                         expected_q[$];
        int mismatches;
        int queries;
        int results;
        int ranges_seen;
        int empty_seen;
        int beyond_seen;

        function new();
            entry_count    = '0;
            entry_clusters = '0;
            entry_windows  = '0;
            core_counts    = '0;
            step           = STEP_W'(1);
            mismatches     = 0;
            queries        = 0;
            results        = 0;
            ranges_seen    = 0;
            empty_seen     = 0;
            beyond_seen    = 0;
        endfunction

        function void set_reg(t_cfg_addr addr, logic [CFG_D_W-1:0] data);
            case (addr)
                CFG_ENTRY_COUNT:    entry_count    = data[2:0];
                CFG_ENTRY_CLUSTERS: entry_clusters = data[PACKED_ENTRIES*CID_W-1:0];
                CFG_ENTRY_WINDOWS:  entry_windows  = data[PACKED_ENTRIES*WIN_W-1:0];
                CFG_CORE_COUNTS:    core_counts    = data[PACKED_CLUSTERS*CNT_W-1:0];
                CFG_STEP:           step           = data[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned live_entries();
            return (int'(entry_count) > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES
                                                          : int'(entry_count);
        endfunction

        function int unsigned cluster_of(int i);
            return 32'(entry_clusters[CID_W*i +: CID_W]);
        endfunction

        function int unsigned window_of(int i);
            return 32'(entry_windows[WIN_W*i +: WIN_W]);
        endfunction

        function int unsigned cores_in(int unsigned cid);
            if (cid >= DEF_MAX_CLUSTERS || cid >= PACKED_CLUSTERS)
                return 0;
            return 32'(core_counts[CNT_W*cid +: CNT_W]);
        endfunction

        function void fill_usable(output int unsigned usable[PACKED_CLUSTERS]);
            int unsigned w;
            int unsigned c;
            foreach (usable[k])
                usable[k] = 0;
            for (int i = 0; i < live_entries(); i++) begin
                c = cores_in(cluster_of(i));
                w = window_of(i);
                usable[cluster_of(i)] += (w < c) ? w : c;
            end
        endfunction

        function int unsigned total_positions();
            int unsigned usable[PACKED_CLUSTERS];
            int unsigned sum;
            sum = 0;
            fill_usable(usable);
            for (int i = 0; i < live_entries(); i++)
                sum += usable[cluster_of(i)];
            return sum;
        endfunction

        function t_work_range work_range_of(logic [IDX_W-1:0] core_index);
            t_work_range r;
            int unsigned usable[PACKED_CLUSTERS];
            int unsigned left;
            int unsigned base;
            int unsigned sz;
            int unsigned win;
            int unsigned avg;
            int unsigned rem;
            int unsigned start_pos;
            int unsigned end_pos;
            int pick;
            r.range_start = '1;
            r.range_end   = '1;
            r.step_out    = '1;
            r.status      = ST_EMPTY;
            if (live_entries() == 0)
                return r;
            fill_usable(usable);
            left = 32'(core_index);
            base = 0;
            pick = -1;
            for (int i = 0; i < live_entries() && pick < 0; i++) begin
                sz = usable[cluster_of(i)];
                if (left < sz) begin
                    pick = i;
                end else begin
                    left -= sz;
                    base += window_of(i);
                end
            end
            if (pick < 0) begin
                r.range_start = '0;
                r.range_end   = '0;
                r.step_out    = '0;
                r.status      = ST_RANGE;
                return r;
            end
            sz        = usable[cluster_of(pick)];
            win       = window_of(pick);
            avg       = win / sz;
            rem       = win % sz;
            start_pos = base + avg * left + ((rem < left) ? rem : left);
            end_pos   = start_pos + avg + ((left < rem) ? 1 : 0);
            r.range_start = RANGE_W'(start_pos * 32'(step));
            r.range_end   = RANGE_W'(end_pos * 32'(step));
            r.step_out    = {1'b0, step};
            r.status      = ST_OK;
            return r;
        endfunction

        function void note_query(logic [IDX_W-1:0] core_index);
            expected_q.insert(expected_q.size(), work_range_of(core_index));
            queries++;
        endfunction

        task report(string what);
            if (mismatches < MAX_PRINTED)
                $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_result(logic signed [RANGE_W-1:0] range_start,
                          logic signed [RANGE_W-1:0] range_end,
                          logic signed [STEP_W:0] step_out, logic [1:0] status);
            t_work_range want;
            if (expected_q.size() == 0) begin
                report("result transfer with no query outstanding");
                return;
            end
            want = expected_q.pop_front();
            results++;
            if (range_start !== want.range_start)
                report($sformatf("result %0d range_start %0d, expected %0d",
                                 results, range_start, want.range_start));
            if (range_end !== want.range_end)
                report($sformatf("result %0d range_end %0d, expected %0d",
                                 results, range_end, want.range_end));
            if (step_out !== want.step_out)
                report($sformatf("result %0d step_out %0d, expected %0d",
                                 results, step_out, want.step_out));
            if (status !== want.status)
                report($sformatf("result %0d status %0d, expected %0d",
                                 results, status, want.status));
            case (want.status)
                ST_OK:    ranges_seen++;
                ST_EMPTY: empty_seen++;
                default:  beyond_seen++;
            endcase
        endtask
    endclass

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_cfg_we     = 1'b0;
    logic [CFG_A_W-1:0]        i_cfg_addr   = CFG_ENTRY_COUNT;
    logic [CFG_D_W-1:0]        i_cfg_data   = '0;
    logic                      i_in_valid   = 1'b0;
    logic                      o_in_ready;
    logic [IDX_W-1:0]          i_core_index = '0;
    logic                      o_out_valid;
    logic                      i_out_ready  = 1'b0;
    logic signed [RANGE_W-1:0] o_range_start;
    logic signed [RANGE_W-1:0] o_range_end;
    logic signed [STEP_W:0]    o_step_out;
    logic [1:0]                o_status;

    range_scoreboard sb = new();
    int cycle_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;

    core_work_range_calc i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_core_index  (i_core_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_range_start (o_range_start),
        .o_range_end   (o_range_end),
        .o_step_out    (o_step_out),
        .o_status      (o_status)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_range_start, o_range_end, o_step_out, o_status);
    end

    task automatic write_reg(t_cfg_addr addr, logic [CFG_D_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(addr, data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic write_setting(logic [2:0] count, logic [11:0] clusters,
                                 logic [47:0] windows, logic [31:0] counts,
                                 logic [11:0] step);
        write_reg(CFG_ENTRY_COUNT, CFG_D_W'(count));
        write_reg(CFG_ENTRY_CLUSTERS, CFG_D_W'(clusters));
        write_reg(CFG_ENTRY_WINDOWS, windows);
        write_reg(CFG_CORE_COUNTS, CFG_D_W'(counts));
        write_reg(CFG_STEP, CFG_D_W'(step));
    endtask

    task automatic send_query(logic [IDX_W-1:0] core_index);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_core_index <= core_index;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sb.note_query(core_index);
    endtask

    // sender holds off until every outstanding result has been checked
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_setting();
        logic [47:0] windows;
        logic [31:0] counts;
        logic [2:0]  count;
        logic [11:0] step;
        int          pick;
        windows = '0;
        counts  = '0;
        for (int i = 0; i < PACKED_ENTRIES; i++) begin
            case ($urandom_range(0, 3))
                0:       windows[WIN_W*i +: WIN_W] = WIN_W'($urandom_range(0, 3));
                1:       windows[WIN_W*i +: WIN_W] = WIN_W'($urandom_range(0, 40));
                2:       windows[WIN_W*i +: WIN_W] = WIN_W'($urandom_range(0, 4095));
                default: windows[WIN_W*i +: WIN_W] = '1;
            endcase
        end
        for (int k = 0; k < PACKED_CLUSTERS; k++) begin
            case ($urandom_range(0, 4))
                0:       counts[CNT_W*k +: CNT_W] = '0;
                1:       counts[CNT_W*k +: CNT_W] = '1;
                default: counts[CNT_W*k +: CNT_W] = CNT_W'($urandom_range(0, 15));
            endcase
        end
        pick = $urandom_range(0, 9);
        if (pick == 0)
            count = '0;
        else if (pick < 8)
            count = 3'($urandom_range(1, 4));
        else
            count = 3'($urandom_range(5, 7));
        case ($urandom_range(0, 3))
            0:       step = '0;
            1:       step = 12'd1;
            2:       step = '1;
            default: step = STEP_W'($urandom_range(0, 4095));
        endcase
        write_setting(count, 12'($urandom_range(0, 4095)), windows, counts, step);
    endtask

    // mostly indexes that land on a core, some just past the end, some anywhere
    function automatic logic [IDX_W-1:0] pick_index();
        int unsigned span;
        span = sb.total_positions();
        if (span == 0 || $urandom_range(0, 7) == 0)
            return IDX_W'($urandom_range(0, 63));
        if ($urandom_range(0, 7) == 0)
            return IDX_W'((span > 63) ? 63 : span);
        return IDX_W'($urandom_range(0, ((span > 64) ? 64 : span) - 1));
    endfunction

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty configuration straight out of reset
        send_query(6'd0);
        send_query(6'd63);
        drain_results();

        // windows at both extremes, uneven split, entry with no usable cores
        write_setting(3'd4, {3'd0, 3'd7, 3'd1, 3'd0},
                      {12'd10, 12'd0, 12'd7, 12'd4095}, 32'h5000_003F, 12'd4095);
        send_query(6'd0);
        send_query(6'd1);
        send_query(6'd24);
        send_query(6'd25);
        send_query(6'd27);
        send_query(6'd28);
        send_query(6'd52);
        send_query(6'd53);
        send_query(6'd63);
        drain_results();

        // entry count saturates, cluster without cores, shared cluster
        write_setting(3'd7, {3'd6, 3'd3, 3'd3, 3'd2},
                      {12'd9, 12'd5, 12'd2, 12'd4095}, 32'h0400_F000, 12'd3);
        send_query(6'd0);
        send_query(6'd6);
        send_query(6'd7);
        send_query(6'd13);
        send_query(6'd14);
        send_query(6'd17);
        send_query(6'd18);

        for (int setting = 0; setting < RANDOM_SETTINGS; setting++) begin
            drain_results();
            case (setting)
                0:       write_setting('1, '1, '1, '1, '1);
                1:       write_setting(3'd4, '0, '0, '0, '0);
                default: random_setting();
            endcase
            for (int mode = 0; mode < 4; mode++) begin
                case (mode)
                    0:       begin idle_pct = 0;  stall_pct = 0;  end
                    1:       begin idle_pct = 50; stall_pct = 0;  end
                    2:       begin idle_pct = 0;  stall_pct = 50; end
                    default: begin idle_pct = 29; stall_pct = 29; end
                endcase
                repeat (ITEMS_PER_MODE) send_query(pick_index());
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
        drain_results();

        $display("covered %0d queries across %0d register settings and four pacing modes",
                 sb.queries, RANDOM_SETTINGS + 3);
        $display("results: %0d work ranges, %0d empty configurations, %0d past the last core",
                 sb.ranges_seen, sb.empty_seen, sb.beyond_seen);
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
